// File: rtl/frenet_to_cartesian_top_defines.svh
// assertion helpers for the rtl
`ifndef FRENET_TO_CARTESIAN_TOP_DEFINES_SVH
`define FRENET_TO_CARTESIAN_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define F2C_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define F2C_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define F2C_ASSERT(lbl, clk, rst_n, prop, msg)
`define F2C_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/f2c_pkg.sv
`default_nettype none
package f2c_pkg;

    localparam int MAX_WAYPOINTS = 32;
    localparam int ADDR_W        = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W         = ADDR_W + 1;
    localparam int CORDIC_STEPS  = 16;
    localparam int ITER_W        = $clog2(CORDIC_STEPS);
    localparam int VEC_SHIFT     = 24;
    localparam int GUARD_BITS    = 8;
    localparam int V_W           = 60;
    localparam int R_W           = 44;
    localparam int S_W           = 45;
    localparam logic signed [28:0] INV_GAIN_Q28 = 29'sd163008219;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    typedef struct packed {
        logic               command;
        logic [4:0]         entry_index;
        logic signed [31:0] arc_pos;
        logic signed [31:0] lateral;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [4:0]         segment_start;
        logic               clamped_start;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] arc;
        logic signed [31:0] xpos;
        logic signed [31:0] ypos;
    } t_waypoint;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_START_RD,
        S_START_LAT,
        S_NEXT_LAT,
        S_MUL_SEG,
        S_MUL_D,
        S_SETUP,
        S_ITER,
        S_FINISH
    } t_state;

endpackage
`default_nettype wire

// File: rtl/f2c_ram.sv
`default_nettype none
module f2c_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/frenet_to_cartesian_top.sv
// load word: written to the table while idle, no result
// convert word: reads and compares table entries until an arc is not below the position or the
// table ends, start and next waypoint reads, two multiplies, setup, 16 cordic iterations, output
// held by output stall, zero-length segments go from first multiply to output; input stalls meanwhile
// synchronous active-low reset: idle, no result pending, waypoint_count = 1
// table contents are not reset and hold garbage until loaded
`default_nettype none
`include "frenet_to_cartesian_top_defines.svh"
module frenet_to_cartesian_top
    import f2c_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire t_in_word i_in,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_out_word  o_out,
    input  wire        i_out_stall,
    input  wire        i_cfg_we,
    input  wire [5:0]  i_cfg_wdata
);

    t_state r_state, n_state;
    logic [5:0] r_count;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_start, n_start;
    logic r_clamped, n_clamped;
    logic signed [31:0] r_s, n_s, r_d, n_d, r_sx, n_sx, r_sy, n_sy;
    logic signed [32:0] r_seg, n_seg, r_dx, n_dx, r_dy, n_dy;
    logic r_zero, n_zero;
    logic signed [61:0] r_prod, n_prod;
    logic signed [R_W-1:0] r_rx, n_rx, r_ry, n_ry;
    logic signed [V_W-1:0] r_vx, n_vx, r_vy, n_vy;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic r_out_valid, n_out_valid;
    t_out_word r_out, n_out;

    logic [CNT_W-1:0] num_wp;
    logic [ADDR_W-1:0] rd_addr;
    t_waypoint rd_wp, wr_wp;
    logic wr_en;
    logic signed [32:0] mul_a;
    logic signed [61:0] mul_p;
    logic [CNT_W-1:0] next_sum;
    logic [ADDR_W-1:0] next_idx;

    f2c_ram #(.WIDTH($bits(t_waypoint)), .DEPTH(MAX_WAYPOINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (i_in.entry_index[ADDR_W-1:0]),
        .i_wdata (wr_wp),
        .i_raddr (rd_addr),
        .o_rdata (rd_wp)
    );

    function automatic logic signed [31:0] sat32(input logic signed [S_W-1:0] v);
        if (v > $signed({{(S_W-31){1'b0}}, {31{1'b1}}})) begin
            sat32 = 32'sh7fffffff;
        end else if (v < $signed({{(S_W-31){1'b1}}, {31{1'b0}}})) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    function automatic logic signed [R_W-1:0] round20(input logic signed [61:0] p);
        logic signed [61:0] t;
        t = p + 62'sd524288;
        round20 = R_W'($signed(t[61:20]));
    endfunction

    always_comb begin
        if (r_count == 6'd0) begin
            num_wp = CNT_W'(1);
        end else if (r_count > 6'(MAX_WAYPOINTS)) begin
            num_wp = CNT_W'(MAX_WAYPOINTS);
        end else begin
            num_wp = CNT_W'(r_count);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign wr_en       = (r_state == S_IDLE) && i_in_valid && (i_in.command == CMD_LOAD);
    assign wr_wp       = '{arc: i_in.arc_pos, xpos: i_in.point_x, ypos: i_in.point_y};

    assign mul_a    = (r_state == S_MUL_D) ? -$signed({r_d[31], r_d}) : r_seg;
    assign mul_p    = mul_a * INV_GAIN_Q28;
    assign next_sum = {1'b0, r_start} + CNT_W'(1);
    assign next_idx = (next_sum >= num_wp) ? '0 : next_sum[ADDR_W-1:0];

    always_comb begin
        logic signed [R_W-1:0] ry_c;
        logic signed [V_W-1:0] vx_c, vy_c;
        logic signed [35:0] rxr, ryr;
        logic signed [R_W-1:0] rxa, rya;
        logic signed [S_W-1:0] ox, oy;

        n_state = r_state;
        n_cnt = r_cnt;
        n_start = r_start;
        n_clamped = r_clamped;
        n_s = r_s;
        n_d = r_d;
        n_sx = r_sx;
        n_sy = r_sy;
        n_seg = r_seg;
        n_dx = r_dx;
        n_dy = r_dy;
        n_zero = r_zero;
        n_prod = r_prod;
        n_rx = r_rx;
        n_ry = r_ry;
        n_vx = r_vx;
        n_vy = r_vy;
        n_iter = r_iter;
        n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        rd_addr = r_cnt[ADDR_W-1:0];
        ry_c = '0;
        vx_c = '0;
        vy_c = '0;
        rxa = r_rx + R_W'(1 << (GUARD_BITS - 1));
        rya = r_ry + R_W'(1 << (GUARD_BITS - 1));
        rxr = rxa[R_W-1:GUARD_BITS];
        ryr = rya[R_W-1:GUARD_BITS];
        ox = '0;
        oy = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in.command == CMD_CONVERT) begin
                    n_s = i_in.arc_pos;
                    n_d = i_in.lateral;
                    n_cnt = '0;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = (r_cnt == num_wp) ? S_START_RD : S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (r_s > rd_wp.arc) begin
                    n_cnt = r_cnt + CNT_W'(1);
                    n_state = S_SCAN_RD;
                end else begin
                    n_state = S_START_RD;
                end
            end
            S_START_RD: begin
                // position at or before the first arc falls back to segment zero
                n_clamped = (r_cnt == '0);
                n_start = (r_cnt == '0) ? '0 : ADDR_W'(r_cnt - CNT_W'(1));
                rd_addr = n_start;
                n_state = S_START_LAT;
            end
            S_START_LAT: begin
                rd_addr = next_idx;
                n_sx = rd_wp.xpos;
                n_sy = rd_wp.ypos;
                n_seg = $signed({r_s[31], r_s}) - $signed({rd_wp.arc[31], rd_wp.arc});
                n_state = S_NEXT_LAT;
            end
            S_NEXT_LAT: begin
                rd_addr = next_idx;
                n_dx = $signed({rd_wp.xpos[31], rd_wp.xpos}) - $signed({r_sx[31], r_sx});
                n_dy = $signed({rd_wp.ypos[31], rd_wp.ypos}) - $signed({r_sy[31], r_sy});
                n_zero = (rd_wp.xpos == r_sx) && (rd_wp.ypos == r_sy);
                n_state = S_MUL_SEG;
            end
            S_MUL_SEG: begin
                n_prod = mul_p;
                n_state = r_zero ? S_FINISH : S_MUL_D;
            end
            S_MUL_D: begin
                n_rx = round20(r_prod);
                n_prod = mul_p;
                n_state = S_SETUP;
            end
            S_SETUP: begin
                ry_c = round20(r_prod);
                vx_c = {{(V_W-33-VEC_SHIFT){r_dx[32]}}, r_dx, {VEC_SHIFT{1'b0}}};
                vy_c = {{(V_W-33-VEC_SHIFT){r_dy[32]}}, r_dy, {VEC_SHIFT{1'b0}}};
                // left half plane: turn both vectors by 180 degrees first
                if (r_dx[32]) begin
                    n_vx = -vx_c;
                    n_vy = -vy_c;
                    n_rx = -r_rx;
                    n_ry = -ry_c;
                end else begin
                    n_vx = vx_c;
                    n_vy = vy_c;
                    n_ry = ry_c;
                end
                n_iter = '0;
                n_state = S_ITER;
            end
            S_ITER: begin
                if (!r_vy[V_W-1]) begin
                    n_vx = r_vx + (r_vy >>> r_iter);
                    n_vy = r_vy - (r_vx >>> r_iter);
                    n_rx = r_rx - (r_ry >>> r_iter);
                    n_ry = r_ry + (r_rx >>> r_iter);
                end else begin
                    n_vx = r_vx - (r_vy >>> r_iter);
                    n_vy = r_vy + (r_vx >>> r_iter);
                    n_rx = r_rx + (r_ry >>> r_iter);
                    n_ry = r_ry - (r_rx >>> r_iter);
                end
                n_iter = r_iter + ITER_W'(1);
                if (r_iter == ITER_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (r_zero) begin
                    ox = $signed({{(S_W-32){r_sx[31]}}, r_sx})
                       + $signed({{(S_W-33){r_seg[32]}}, r_seg});
                    oy = $signed({{(S_W-32){r_sy[31]}}, r_sy})
                       - $signed({{(S_W-32){r_d[31]}}, r_d});
                end else begin
                    ox = $signed({{(S_W-32){r_sx[31]}}, r_sx})
                       + $signed({{(S_W-36){rxr[35]}}, rxr});
                    oy = $signed({{(S_W-32){r_sy[31]}}, r_sy})
                       + $signed({{(S_W-36){ryr[35]}}, ryr});
                end
                // hold the result back while the previous word is still stalled
                if (!(r_out_valid && i_out_stall)) begin
                    n_out.pos_x = sat32(ox);
                    n_out.pos_y = sat32(oy);
                    n_out.segment_start = 5'(r_start);
                    n_out.clamped_start = r_clamped;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count <= 6'd1;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_start <= n_start;
        r_clamped <= n_clamped;
        r_s <= n_s;
        r_d <= n_d;
        r_sx <= n_sx;
        r_sy <= n_sy;
        r_seg <= n_seg;
        r_dx <= n_dx;
        r_dy <= n_dy;
        r_zero <= n_zero;
        r_prod <= n_prod;
        r_rx <= n_rx;
        r_ry <= n_ry;
        r_vx <= n_vx;
        r_vy <= n_vy;
        r_iter <= n_iter;
        r_out <= n_out;
    end

    `F2C_ASSERT_NR(a_reset_quiet, i_clk, !i_rst_n |=> (!o_out_valid && r_state == S_IDLE), "reset left block busy")
    `F2C_ASSERT(a_iter_nonzero, i_clk, i_rst_n, (r_state == S_ITER) |-> !r_zero, "cordic on zero segment")
    `F2C_ASSERT(a_scan_bound, i_clk, i_rst_n, (r_state == S_SCAN_CMP) |-> (r_cnt < num_wp), "scan past table end")
    `F2C_ASSERT(a_finish_out, i_clk, i_rst_n, (r_state == S_FINISH && !(r_out_valid && i_out_stall)) |=> o_out_valid, "result lost at finish")

endmodule
`default_nettype wire
